/* rtl/core/pfds_pkg.sv */
// Package for the prime factorization / divisor statistics block.
// Field widths, saturation limits, sequencer state type and the control structs.
// No dependencies.
`default_nettype none

package pfds_pkg;

  // default operand width and the widths derived from it
  localparam int VALUE_BITS_DEF = 20;
  localparam int DIVISOR_W_DEF  = (VALUE_BITS_DEF + 1) / 2 + 1;
  localparam int STEP_W_DEF     = $clog2(VALUE_BITS_DEF + 1);

  // result field widths
  localparam int VALUE_W    = 20;
  localparam int PRIME_W    = 20;
  localparam int DISTINCT_W = 3;
  localparam int TOTAL_W    = 5;
  localparam int DCOUNT_W   = 8;
  localparam int DSUM_W     = 24;

  localparam logic [PRIME_W-1:0]    PRIME_MAX    = '1;
  localparam logic [DISTINCT_W-1:0] DISTINCT_MAX = '1;
  localparam logic [TOTAL_W-1:0]    TOTAL_MAX    = '1;
  localparam logic [DCOUNT_W-1:0]   DCOUNT_MAX   = '1;
  localparam logic [DSUM_W-1:0]     DSUM_MAX     = '1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_WAIT,
    ST_TERM,
    ST_RECORD,
    ST_ADVANCE,
    ST_FINAL,
    ST_DONE
  } state_e;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic start;
    logic psq_le_n;
    logic div_done;
    logic rem_zero;
    logic e_nz;
  } status_t;

  // sequencer commands to the datapath
  typedef struct packed {
    logic busy;
    logic load;
    logic div_start;
    logic take_quot;
    logic mul_term;
    logic record;
    logic advance;
    logic finish;
    logic result;
  } ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/pfds_divider.sv */
// Bit-serial shift/subtract divider, one quotient bit per cycle.
// Starts from a pre-aligned partial remainder; step count supplied by caller.
// Depends on pfds_pkg for parameter defaults.
`default_nettype none

module pfds_divider import pfds_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int DIVISOR_W  = DIVISOR_W_DEF,
  parameter int STEP_W     = STEP_W_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  input  logic [STEP_W-1:0]     steps_i,
  output logic                  done_o,
  output logic [VALUE_BITS-1:0] quotient_o,
  output logic                  rem_zero_o
);

  localparam logic [STEP_W-1:0] VB_S = STEP_W'(VALUE_BITS);

  logic [VALUE_BITS-1:0] w_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [STEP_W-1:0]     cnt_q;
  logic                  run_q;
  logic                  done_q;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  assign trial = {rem_q, w_q[VALUE_BITS-1]};
  assign ge    = trial >= {1'b0, divisor_i};
  assign diff  = trial - {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= steps_i;
      end else if (run_q) begin
        cnt_q <= cnt_q - STEP_W'(1);
        if (cnt_q == STEP_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // top bits of the dividend seed the remainder (always below the divisor),
  // the rest is shifted in one bit a cycle while quotient bits fill from below
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DIVISOR_W'(dividend_i >> steps_i);
      w_q   <= dividend_i << (VB_S - steps_i);
    end else if (run_q) begin
      rem_q <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      w_q   <= {w_q[VALUE_BITS-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = w_q;
  assign rem_zero_o = (rem_q == '0);

endmodule

`default_nettype wire

/* rtl/core/pfds_ctrl.sv */
// Sequencer for trial division: candidate check, divide, factor bookkeeping.
// Depends on pfds_pkg (state_e, status_t, ctrl_t).
`default_nettype none

module pfds_ctrl import pfds_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (status_i.start) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = status_i.psq_le_n ? ST_DIV : ST_FINAL;
      end
      ST_DIV: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (status_i.div_done) begin
          if (status_i.rem_zero) begin
            state_d = ST_TERM;
          end else if (status_i.e_nz) begin
            state_d = ST_RECORD;
          end else begin
            state_d = ST_ADVANCE;
          end
        end
      end
      ST_TERM:    state_d = ST_DIV;
      ST_RECORD:  state_d = ST_ADVANCE;
      ST_ADVANCE: state_d = ST_CHECK;
      ST_FINAL:   state_d = ST_DONE;
      ST_DONE:    state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o           = '0;
    ctrl_o.busy      = (state_q != ST_IDLE);
    ctrl_o.load      = (state_q == ST_IDLE) && status_i.start;
    ctrl_o.div_start = (state_q == ST_DIV);
    ctrl_o.take_quot = (state_q == ST_WAIT) && status_i.div_done && status_i.rem_zero;
    ctrl_o.mul_term  = (state_q == ST_TERM);
    ctrl_o.record    = (state_q == ST_RECORD);
    ctrl_o.advance   = (state_q == ST_ADVANCE);
    ctrl_o.finish    = (state_q == ST_FINAL);
    ctrl_o.result    = (state_q == ST_DONE);
  end

endmodule

`default_nettype wire

/* rtl/core/prime_factor_divisor_stats.sv */
// Top level of the prime factorization / divisor statistics block.
// Depends on pfds_pkg, pfds_divider and pfds_ctrl.
`default_nettype none

// Usage
// -----
// Command port: a transaction is taken on the clock edge where start is high
// and busy is low; value_i is sampled then (low VALUE_BITS bits used).
// busy stays high from the next cycle until the result has been shown.
// Result port: valid_o is high for exactly one cycle, with all six fields
// on their ports in that cycle. The receiver cannot stall; the result is
// gone after that cycle. One result per transaction.
//
// Method: trial division by 2, then odd candidates p while p*p <= n. Each
// candidate costs one remainder computation in the bit-serial divider and
// one pass through the sequencer states; each factor found costs one more
// division and a multiply, each distinct prime one record. The worst case
// at 20 bits is a prime near 2^20, with 512 candidates; small values
// finish far sooner.
//
// Reset (rst_ni low, asynchronous) returns the sequencer to idle; an
// item in flight is dropped and no result is produced for it.
module prime_factor_divisor_stats import pfds_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_W-1:0]    value_i,
  output logic                  valid_o,
  output logic [PRIME_W-1:0]    smallest_prime_o,
  output logic [PRIME_W-1:0]    largest_prime_o,
  output logic [DISTINCT_W-1:0] distinct_primes_o,
  output logic [TOTAL_W-1:0]    total_primes_o,
  output logic [DCOUNT_W-1:0]   divisor_count_o,
  output logic [DSUM_W-1:0]     divisor_sum_o
);

  localparam int VB     = VALUE_BITS;
  localparam int P_W    = (VB + 1) / 2 + 1;      // trial divisor width
  localparam int PS_W   = VB + 2;                // p*p, one candidate past sqrt
  localparam int PL_W   = $clog2(P_W + 2);       // bit length of p
  localparam int K_W    = $clog2(VB + 1);        // divider step count
  localparam int CNT_W  = $clog2(VB + 1);        // exponent and prime counts
  localparam int TERM_W = VB + 1;                // 1 + p + ... + p^e < 2n
  localparam int SUM_W  = VB + 3;                // sigma(n) < 8n
  localparam int DC_W   = (VB + 1) / 2 + 2;      // d(n) <= 2*sqrt(n)
  localparam int MUL_W  = SUM_W + TERM_W;
  localparam int DCP_W  = DC_W + CNT_W + 1;
  localparam int CMP_W  = SUM_W + DSUM_W;

  localparam logic [K_W-1:0] VB_K = K_W'(VB);

  ctrl_t   ctrl;
  status_t status;

  // working state of the factorization
  logic [VB-1:0]     n_q;
  logic [P_W-1:0]    p_q;
  logic [PS_W-1:0]   psq_q;
  logic [P_W:0]      pow2_q;     // next power of two above p
  logic [PL_W-1:0]   plen_q;
  logic [CNT_W-1:0]  e_q;
  logic [TERM_W-1:0] term_q;

  // accumulated statistics
  logic [VB-1:0]     spf_q;
  logic [VB-1:0]     gpf_q;
  logic [CNT_W-1:0]  distinct_q;
  logic [CNT_W-1:0]  total_q;
  logic [DC_W-1:0]   dcount_q;
  logic [SUM_W-1:0]  dsum_q;

  logic [K_W-1:0]    steps;
  logic              div_done;
  logic              rem_zero;
  logic [VB-1:0]     quotient;

  logic [P_W-1:0]    p_next;
  logic [PS_W-1:0]   psq_next;
  logic              n_gt_one;

  logic [SUM_W-1:0]  mul_a;
  logic [TERM_W-1:0] mul_b;
  logic [MUL_W-1:0]  prod;
  logic [CNT_W:0]    e_inc;
  logic [DCP_W-1:0]  dc_prod;

  pfds_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  // quotient bits needed: VB - bitlen(p) + 1; the rest seeds the remainder
  assign steps = VB_K - K_W'(plen_q) + K_W'(1);

  pfds_divider #(
    .VALUE_BITS (VB),
    .DIVISOR_W  (P_W),
    .STEP_W     (K_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl.div_start),
    .dividend_i (n_q),
    .divisor_i  (p_q),
    .steps_i    (steps),
    .done_o     (div_done),
    .quotient_o (quotient),
    .rem_zero_o (rem_zero)
  );

  assign status.start    = start;
  assign status.psq_le_n = (psq_q <= PS_W'(n_q));
  assign status.div_done = div_done;
  assign status.rem_zero = rem_zero;
  assign status.e_nz     = (e_q != '0);

  assign n_gt_one = (n_q > VB'(1));

  // candidate sequence 2, 3, 5, 7, ... with p*p kept incrementally:
  // (p+2)^2 = p^2 + 4p + 4
  assign p_next   = (p_q == P_W'(2)) ? P_W'(3) : p_q + P_W'(2);
  assign psq_next = (p_q == P_W'(2)) ? PS_W'(9)
                                     : psq_q + (PS_W'(p_q) << 2) + PS_W'(4);

  // one multiplier, shared by the power-sum update and the sigma products
  always_comb begin
    mul_a = SUM_W'(term_q);
    mul_b = TERM_W'(p_q);
    if (ctrl.record) begin
      mul_a = dsum_q;
      mul_b = term_q;
    end else if (ctrl.finish) begin
      mul_a = dsum_q;
      mul_b = TERM_W'(n_q) + TERM_W'(1);
    end
  end

  assign prod    = mul_a * mul_b;
  assign e_inc   = {1'b0, e_q} + (CNT_W + 1)'(1);
  assign dc_prod = dcount_q * e_inc;

  always_ff @(posedge clk_i) begin
    if (ctrl.load) begin
      n_q        <= VB'(value_i);
      p_q        <= P_W'(2);
      psq_q      <= PS_W'(4);
      pow2_q     <= (P_W + 1)'(4);
      plen_q     <= PL_W'(2);
      e_q        <= '0;
      term_q     <= TERM_W'(1);
      spf_q      <= '0;
      gpf_q      <= '0;
      distinct_q <= '0;
      total_q    <= '0;
      dcount_q   <= DC_W'(1);
      dsum_q     <= SUM_W'(1);
    end
    if (ctrl.take_quot) begin
      n_q <= quotient;
      e_q <= e_q + CNT_W'(1);
    end
    if (ctrl.mul_term) begin
      term_q <= TERM_W'(prod) + TERM_W'(1);   // Horner: term*p + 1
    end
    if (ctrl.record) begin
      dsum_q     <= SUM_W'(prod);
      dcount_q   <= DC_W'(dc_prod);
      distinct_q <= distinct_q + CNT_W'(1);
      total_q    <= total_q + e_q;
      gpf_q      <= VB'(p_q);
      if (spf_q == '0) spf_q <= VB'(p_q);
    end
    if (ctrl.advance) begin
      p_q    <= p_next;
      psq_q  <= psq_next;
      e_q    <= '0;
      term_q <= TERM_W'(1);
      if ({1'b0, p_next} >= pow2_q) begin
        pow2_q <= pow2_q << 1;
        plen_q <= plen_q + PL_W'(1);
      end
    end
    // leftover above one is a prime larger than every candidate tried
    if (ctrl.finish && n_gt_one) begin
      dsum_q     <= SUM_W'(prod);
      dcount_q   <= DC_W'({dcount_q, 1'b0});
      distinct_q <= distinct_q + CNT_W'(1);
      total_q    <= total_q + CNT_W'(1);
      gpf_q      <= n_q;
      if (spf_q == '0) spf_q <= n_q;
    end
  end

  assign busy    = ctrl.busy;
  assign valid_o = ctrl.result;

  // clamp each field at its all-ones value (only reachable for wide VALUE_BITS)
  assign smallest_prime_o  = (CMP_W'(spf_q) > CMP_W'(PRIME_MAX)) ? PRIME_MAX
                                                                 : PRIME_W'(spf_q);
  assign largest_prime_o   = (CMP_W'(gpf_q) > CMP_W'(PRIME_MAX)) ? PRIME_MAX
                                                                 : PRIME_W'(gpf_q);
  assign distinct_primes_o = (CMP_W'(distinct_q) > CMP_W'(DISTINCT_MAX)) ? DISTINCT_MAX
                                                                   : DISTINCT_W'(distinct_q);
  assign total_primes_o    = (CMP_W'(total_q) > CMP_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                                   : TOTAL_W'(total_q);
  assign divisor_count_o   = (CMP_W'(dcount_q) > CMP_W'(DCOUNT_MAX)) ? DCOUNT_MAX
                                                                     : DCOUNT_W'(dcount_q);
  assign divisor_sum_o     = (CMP_W'(dsum_q) > CMP_W'(DSUM_MAX)) ? DSUM_MAX
                                                                 : DSUM_W'(dsum_q);

`ifndef ASSERT_OFF
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");

  a_divisors_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (divisor_count_o != '0) && (divisor_sum_o != '0))
    else $error("divisor count or sum is zero");

  a_prime_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (smallest_prime_o <= largest_prime_o) &&
                (distinct_primes_o <= total_primes_o))
    else $error("prime factor statistics inconsistent");
`endif

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for prime_factor_divisor_stats (command port in, strobed result out).
// Needs pfds_pkg and the block's RTL; predicts each result with its own trial-division model.
// Directed corner values first, then mostly smooth numbers and small values, a few full-width.
`default_nettype none

module tb_top;
  import pfds_pkg::*;

  localparam int          VALUE_BITS  = VALUE_BITS_DEF;
  localparam int          MISMATCH_SHOWN = 10;
  localparam int          RANDOM_ITEMS   = 1000;
  // Worst case is a prime near 2^20; the limit sits above the run time of every
  // item at worst case plus sender gaps.
  localparam longint      CYCLE_LIMIT = 40_000_000;
  localparam int          GAP_PCT     = 15;
  // transactions in this window are sent back to back, no sender gaps
  localparam int          NO_GAP_FROM = 300;
  localparam int          NO_GAP_TO   = 450;

  typedef struct packed {
    logic [PRIME_W-1:0]    smallest;
    logic [PRIME_W-1:0]    largest;
    logic [DISTINCT_W-1:0] distinct;
    logic [TOTAL_W-1:0]    total;
    logic [DCOUNT_W-1:0]   dcount;
    logic [DSUM_W-1:0]     dsum;
  } factor_stats_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic [VALUE_W-1:0]    value_i = '0;
  logic                  busy;
  logic                  valid_o;
  logic [PRIME_W-1:0]    smallest_prime_o;
  logic [PRIME_W-1:0]    largest_prime_o;
  logic [DISTINCT_W-1:0] distinct_primes_o;
  logic [TOTAL_W-1:0]    total_primes_o;
  logic [DCOUNT_W-1:0]   divisor_count_o;
  logic [DSUM_W-1:0]     divisor_sum_o;

  prime_factor_divisor_stats #(
    .VALUE_BITS(VALUE_BITS)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .value_i          (value_i),
    .valid_o          (valid_o),
    .smallest_prime_o (smallest_prime_o),
    .largest_prime_o  (largest_prime_o),
    .distinct_primes_o(distinct_primes_o),
    .total_primes_o   (total_primes_o),
    .divisor_count_o  (divisor_count_o),
    .divisor_sum_o    (divisor_sum_o)
  );

  // numbers waiting to be sent, and the stats owed for numbers already taken
  logic [VALUE_W-1:0] numbers_pending[$];
  factor_stats_t      stats_due[$];

  int     sent_cnt = 0;
  int     checked_cnt = 0;
  int     mismatch_cnt = 0;
  int     directed_cnt = 0;
  int     prime_cnt = 0;
  int     seven_distinct_cnt = 0;
  int     max_dcount = 0;
  longint cycle_cnt = 0;

  // Clamp to an all-ones field, as the block does when a wide VALUE_BITS overflows.
  function automatic longint unsigned clamp(longint unsigned v, int bits);
    longint unsigned top;
    top = (64'd1 << bits) - 1;
    return (v > top) ? top : v;
  endfunction

  // Trial division: 2, then odd candidates while p*p <= remaining n; whatever
  // is left above 1 is a prime larger than any candidate tried.
  function automatic factor_stats_t factorize(logic [VALUE_W-1:0] raw);
    longint unsigned n, p, e, term, pw;
    longint unsigned spf, gpf, distinct, total, dcount, dsum;
    factor_stats_t   r;
    n = 64'(raw) & ((64'd1 << VALUE_BITS) - 1);
    spf = 0; gpf = 0; distinct = 0; total = 0;
    dcount = 1; dsum = 1;
    p = 2;
    // zero and one fall through: no primes, one divisor summing to one
    if (n >= 2) begin
      while (p * p <= n) begin
        if (n % p == 0) begin
          e = 0; term = 1; pw = 1;
          while (n % p == 0) begin
            n = n / p;
            e++;
            pw = pw * p;
            term = term + pw;
          end
          if (spf == 0) spf = p;
          gpf = p;
          distinct++;
          total = total + e;
          dcount = dcount * (e + 1);
          dsum = dsum * term;
        end
        p = (p == 2) ? 3 : p + 2;
      end
      if (n > 1) begin
        if (spf == 0) spf = n;
        gpf = n;
        distinct++;
        total++;
        dcount = dcount * 2;
        dsum = dsum * (n + 1);
      end
    end
    r.smallest = PRIME_W'(clamp(spf, PRIME_W));
    r.largest  = PRIME_W'(clamp(gpf, PRIME_W));
    r.distinct = DISTINCT_W'(clamp(distinct, DISTINCT_W));
    r.total    = TOTAL_W'(clamp(total, TOTAL_W));
    r.dcount   = DCOUNT_W'(clamp(dcount, DCOUNT_W));
    r.dsum     = DSUM_W'(clamp(dsum, DSUM_W));
    return r;
  endfunction

  // Random prime up to hi, found by rejection against the predictor.
  function automatic int unsigned random_prime(int unsigned hi);
    int unsigned   p;
    factor_stats_t s;
    do begin
      p = $urandom_range(hi, 2);
      s = factorize(VALUE_W'(p));
    end while (s.total != 1);
    return p;
  endfunction

  // Product of random prime powers that fits the field: these finish quickly
  // and drive the counts and the divisor sum high.
  function automatic logic [VALUE_W-1:0] smooth_number();
    longint unsigned n, p;
    int              steps;
    n = 1;
    steps = $urandom_range(20, 1);
    repeat (steps) begin
      p = ($urandom_range(99) < 80) ? random_prime(50) : random_prime(2000);
      if (n * p < (64'd1 << VALUE_W)) n = n * p;
    end
    return VALUE_W'(n);
  endfunction

  // Compare one field; only the first few mismatches are printed in full.
  task automatic check_field(string name, longint unsigned want, longint unsigned got,
                             logic [VALUE_W-1:0] num);
    if (want != got) begin
      mismatch_cnt++;
      if (mismatch_cnt <= MISMATCH_SHOWN)
        $display("mismatch on %s for result %0d (value %0d): expected %0d, got %0d",
                 name, checked_cnt, num, want, got);
    end
  endtask

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  // Driver: a transaction is taken at the edge where start is high and busy low.
  // start stays up while busy holds the item off; after a take it either moves
  // straight to the next number or drops for a random gap.
  wire take_w = start && !busy;
  logic [VALUE_W-1:0] value_sent[$];

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start   <= 1'b0;
      value_i <= '0;
    end else begin
      if (take_w) begin
        stats_due.push_back(factorize(value_i));
        value_sent.push_back(value_i);
        sent_cnt <= sent_cnt + 1;
      end
      if (!start || take_w) begin
        if (numbers_pending.size() > 0 &&
            ((sent_cnt >= NO_GAP_FROM && sent_cnt < NO_GAP_TO) ||
             $urandom_range(99) >= GAP_PCT)) begin
          start   <= 1'b1;
          value_i <= numbers_pending.pop_front();
        end else begin
          // idle: value is a don't-care, keep it moving
          start   <= 1'b0;
          value_i <= VALUE_W'($urandom);
        end
      end
    end
  end

  // Monitor: valid_o lasts one cycle and cannot be held off.
  always @(posedge clk_i) begin
    factor_stats_t      want;
    logic [VALUE_W-1:0] num;
    if (rst_ni && valid_o) begin
      if (stats_due.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MISMATCH_SHOWN)
          $display("result with no transaction outstanding: smallest %0d largest %0d",
                   smallest_prime_o, largest_prime_o);
      end else begin
        want = stats_due.pop_front();
        num  = value_sent.pop_front();
        check_field("smallest_prime", want.smallest, smallest_prime_o, num);
        check_field("largest_prime", want.largest, largest_prime_o, num);
        check_field("distinct_primes", want.distinct, distinct_primes_o, num);
        check_field("total_primes", want.total, total_primes_o, num);
        check_field("divisor_count", want.dcount, divisor_count_o, num);
        check_field("divisor_sum", want.dsum, divisor_sum_o, num);
        if (want.total == 1) prime_cnt++;
        if (want.distinct == 7) seven_distinct_cnt++;
        if (int'(want.dcount) > max_dcount) max_dcount = int'(want.dcount);
        checked_cnt++;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int r;
    // directed: zero and one, tiny primes and powers, all-ones, largest prime
    // below 2^20, a prime square and twin-prime product near the top (the
    // p*p <= n boundary), top powers of two, seven distinct primes, big divisor count
    numbers_pending.push_back(20'd0);
    numbers_pending.push_back(20'd1);
    numbers_pending.push_back(20'd2);
    numbers_pending.push_back(20'd3);
    numbers_pending.push_back(20'd4);
    numbers_pending.push_back(20'd6);
    numbers_pending.push_back(20'd9);
    numbers_pending.push_back(20'd25);
    numbers_pending.push_back(20'd961);
    numbers_pending.push_back(20'd65536);
    numbers_pending.push_back(20'd1048575);
    numbers_pending.push_back(20'd1048574);
    numbers_pending.push_back(20'd1048573);
    numbers_pending.push_back(20'd999983);
    numbers_pending.push_back(20'd524287);
    numbers_pending.push_back(20'd524288);
    numbers_pending.push_back(20'd786432);
    numbers_pending.push_back(20'd510510);
    numbers_pending.push_back(20'd720720);
    numbers_pending.push_back(20'd1042441);
    numbers_pending.push_back(20'd1040399);
    numbers_pending.push_back(20'd1000000);
    directed_cnt = numbers_pending.size();

    // random: run time grows with the square root of the cofactor, so most
    // numbers are smooth or small and only a few span the full width
    repeat (RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (r < 40)      numbers_pending.push_back(smooth_number());
      else if (r < 70) numbers_pending.push_back(VALUE_W'($urandom_range(1023, 0)));
      else if (r < 85) numbers_pending.push_back(VALUE_W'($urandom_range(16383, 0)));
      else if (r < 95) numbers_pending.push_back(VALUE_W'($urandom_range(65535, 0)));
      else             numbers_pending.push_back(VALUE_W'($urandom));
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sampled on the falling edge, clear of the driver and monitor updates
    do @(negedge clk_i);
    while (numbers_pending.size() > 0 || start || stats_due.size() > 0);
    repeat (20) @(negedge clk_i);

    if (stats_due.size() > 0) begin
      mismatch_cnt = mismatch_cnt + stats_due.size();
      $display("%0d results never arrived", stats_due.size());
    end
    $display("factorized %0d numbers (%0d directed), %0d results checked, %0d mismatches",
             sent_cnt, directed_cnt, checked_cnt, mismatch_cnt);
    $display("primes seen %0d, seven-prime values %0d, largest divisor count %0d",
             prime_cnt, seven_distinct_cnt, max_dcount);
    if (mismatch_cnt == 0) begin
      $display("[prime_factor_divisor_stats] OK");
    end else begin
      $display("[prime_factor_divisor_stats] ERROR");
    end
    $finish;
  end

  // Watchdog on the cycle counter.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(negedge clk_i);
    $display("timeout after %0d cycles, %0d of %0d results seen",
             cycle_cnt, checked_cnt, sent_cnt);
    $display("[prime_factor_divisor_stats] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
